// ----- hw/rtl/hets_pkg.sv -----
package hets_pkg;
    localparam int BinDepth   = 1024;
    localparam int CountWidth = 32;
    localparam int AddrWidth  = $clog2(BinDepth);
    localparam int LoadWidth  = $clog2(BinDepth + 1);
    localparam int TotalWidth = CountWidth + LoadWidth;
    localparam int EffWidth   = 17;
    localparam int PosWidth   = 10;
    localparam int NumWidth   = TotalWidth + 17;
    localparam int QuotWidth  = 17;
    localparam int DistWidth  = EffWidth + 1;

    localparam logic [1:0] RegTarget  = 2'd0;
    localparam logic [1:0] RegMatchOn = 2'd1;

    typedef struct packed {
        logic                found;
        logic [PosWidth-1:0] cut_position;
        logic [EffWidth-1:0] signal_efficiency;
        logic [EffWidth-1:0] background_efficiency;
        logic                zero_total;
        logic                store_overflow;
    } t_result;

    typedef struct packed {
        logic [CountWidth-1:0] signal_count;
        logic [CountWidth-1:0] background_count;
        logic                  last_bin;
    } t_bin;
endpackage

// ----- hw/rtl/hets_stream_if.sv -----
interface hets_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/histogram_efficiency_threshold_search.sv -----
// Channel    Dir  Payload
// i_bin      in   signal_count, background_count, last_bin
// o_result   out  found, cut_position, signal/background_efficiency, zero_total,
//                 store_overflow
// Bins load one per cycle into two memories while ready is high. On the last bin a
// sequencer walks every stored position; at each position the shared restoring
// divider yields two efficiencies in turn, signal then background (17 quotient
// bits each). Ready is low from the last bin until the result is registered; a
// result not yet taken holds the search in its final step. Reset is synchronous,
// active low; memories get no clear.
module histogram_efficiency_threshold_search
    import hets_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hets_stream_if.sink   i_bin,
    hets_stream_if.source o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [2:0] {
        S_LOAD, S_READ, S_SETUP, S_DIV, S_NEXT, S_EVAL, S_DONE
    } t_state;

    t_state r_state;
    logic [EffWidth-1:0] r_target;
    logic                r_match_on;

    logic [CountWidth-1:0] r_sig_mem [BinDepth];
    logic [CountWidth-1:0] r_bkg_mem [BinDepth];
    logic [CountWidth-1:0] r_sig_rd, r_bkg_rd;

    logic [LoadWidth-1:0]  r_loaded;
    logic [TotalWidth-1:0] r_sig_total, r_bkg_total;
    logic [TotalWidth-1:0] r_sig_before, r_bkg_before;
    logic                  r_ovf;
    logic [LoadWidth-1:0]  r_pos;

    logic                  r_kind;      // 0 signal division, 1 background
    logic [NumWidth-1:0]   r_rem;
    logic [TotalWidth-1:0] r_den;
    logic [QuotWidth-1:0]  r_quot;
    logic [4:0]            r_bit;
    logic [EffWidth-1:0]   r_se, r_be;

    logic                  r_found;
    logic [DistWidth-1:0]  r_best_dist;
    logic [PosWidth-1:0]   r_best_pos;
    logic [EffWidth-1:0]   r_best_se, r_best_be;

    t_result r_out;
    logic    r_out_valid;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            RegTarget[0]: prdata = {15'd0, r_target};
            default:      prdata = {31'd0, r_match_on};
        endcase
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;

    assign i_bin.ready      = (r_state == S_LOAD);
    assign o_result.valid   = r_out_valid;
    assign o_result.data    = r_out;

    logic bin_acc;
    assign bin_acc = i_bin.valid && i_bin.ready;
    logic room;
    assign room = r_loaded < LoadWidth'(BinDepth);

    always_ff @(posedge i_clk) begin
        if (bin_acc && room) begin
            r_sig_mem[r_loaded[AddrWidth-1:0]] <= i_bin.data.signal_count;
            r_bkg_mem[r_loaded[AddrWidth-1:0]] <= i_bin.data.background_count;
        end
        r_sig_rd <= r_sig_mem[r_pos[AddrWidth-1:0]];
        r_bkg_rd <= r_bkg_mem[r_pos[AddrWidth-1:0]];
    end

    // One restoring step: subtract the divisor shifted to the current bit.
    logic [NumWidth:0] trial;
    logic [NumWidth:0] shifted_den;
    assign shifted_den = {{(NumWidth+1-TotalWidth){1'b0}}, r_den} << r_bit;
    assign trial = {1'b0, r_rem} - shifted_den;

    logic [EffWidth-1:0]  m_eff;
    logic [DistWidth-1:0] m_dist;
    assign m_eff  = r_match_on ? r_be : r_se;
    assign m_dist = ({1'b0, r_target} > {1'b0, m_eff}) ?
                    {1'b0, r_target} - {1'b0, m_eff} : {1'b0, m_eff} - {1'b0, r_target};

    logic [TotalWidth-1:0] tail;
    assign tail = r_kind ? (r_bkg_total - r_bkg_before) : (r_sig_total - r_sig_before);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_target    <= '0;
            r_match_on  <= 1'b0;
            r_loaded    <= '0;
            r_sig_total <= '0;
            r_bkg_total <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    RegTarget[0]:  r_target   <= pwdata[EffWidth-1:0];
                    default:       r_match_on <= pwdata[0];
                endcase
            end
            if (o_result.valid && o_result.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (bin_acc) begin
                        if (room) begin
                            r_loaded    <= r_loaded + 1'b1;
                            r_sig_total <= r_sig_total + TotalWidth'(i_bin.data.signal_count);
                            r_bkg_total <= r_bkg_total +
                                           TotalWidth'(i_bin.data.background_count);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_bin.data.last_bin) begin
                            r_state      <= S_READ;
                            r_pos        <= '0;
                            r_sig_before <= '0;
                            r_bkg_before <= '0;
                            r_found      <= 1'b0;
                            r_best_dist  <= {1'b0, r_target};
                            r_best_pos   <= '0;
                            r_best_se    <= '0;
                            r_best_be    <= '0;
                            r_kind       <= 1'b0;
                        end
                    end
                end
                S_READ: begin
                    if (r_pos >= r_loaded) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SETUP;
                        r_kind  <= 1'b0;
                    end
                end
                S_SETUP: begin
                    r_den   <= r_kind ? r_bkg_total : r_sig_total;
                    r_rem   <= NumWidth'({tail, 16'd0}) +
                               NumWidth'((r_kind ? r_bkg_total : r_sig_total) >> 1);
                    r_quot  <= '0;
                    r_bit   <= 5'(QuotWidth - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!trial[NumWidth]) begin
                        r_rem  <= trial[NumWidth-1:0];
                        r_quot <= r_quot | (QuotWidth'(1) << r_bit);
                    end
                    if (r_bit == 5'd0) r_state <= S_NEXT;
                    r_bit <= r_bit - 1'b1;
                end
                S_NEXT: begin
                    if (!r_kind) begin
                        r_se    <= (r_den == '0) ? '0 : r_quot;
                        r_kind  <= 1'b1;
                        r_state <= S_SETUP;
                    end else begin
                        r_be    <= (r_den == '0) ? '0 : r_quot;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (m_dist < r_best_dist) begin
                        r_best_dist <= m_dist;
                        r_found     <= 1'b1;
                        r_best_pos  <= r_pos[PosWidth-1:0];
                        r_best_se   <= r_se;
                        r_best_be   <= r_be;
                    end
                    r_sig_before <= r_sig_before + TotalWidth'(r_sig_rd);
                    r_bkg_before <= r_bkg_before + TotalWidth'(r_bkg_rd);
                    r_pos        <= r_pos + 1'b1;
                    r_state      <= S_READ;
                end
                S_DONE: begin
                    // Waits here while the previous result is still unclaimed.
                    if (!r_out_valid) begin
                        r_out.found                 <= r_found;
                        r_out.cut_position          <= r_best_pos;
                        r_out.signal_efficiency     <= r_best_se;
                        r_out.background_efficiency <= r_best_be;
                        r_out.zero_total  <= (r_sig_total == '0) || (r_bkg_total == '0);
                        r_out.store_overflow        <= r_ovf;
                        r_out_valid <= 1'b1;
                        r_loaded    <= '0;
                        r_sig_total <= '0;
                        r_bkg_total <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule

// ----- tb/hets_checker.sv -----
module hets_checker
    import hets_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_bin_valid,
    input  logic        i_bin_ready,
    input  t_bin        i_bin_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  t_result     i_res_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_checked
);
    localparam logic MatchBackground = 1'b1;

    typedef longint unsigned u64;

    u64               sig_bins [BinDepth];
    u64               bkg_bins [BinDepth];
    int               loaded;
    u64               sig_sum;
    u64               bkg_sum;
    bit               dropped;
    logic [16:0]      target;
    logic             match_sel;
    t_result          expected_results [$];

    function automatic u64 tail_fraction(u64 tail, u64 total);
        if (total == 0) return 0;
        return ((tail << 16) + (total >> 1)) / total;
    endfunction

    function automatic u64 gap_to(u64 a, u64 b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Walks every loaded position and keeps the one nearest the target.
    function automatic t_result search_threshold();
        t_result r;
        u64      sig_head, bkg_head, best_m, se, be, m;
        r        = '0;
        sig_head = 0;
        bkg_head = 0;
        best_m   = 0;
        for (int p = 0; p < loaded; p++) begin
            se = tail_fraction(sig_sum - sig_head, sig_sum);
            be = tail_fraction(bkg_sum - bkg_head, bkg_sum);
            m  = (match_sel == MatchBackground) ? be : se;
            if (gap_to(u64'(target), m) < gap_to(u64'(target), best_m)) begin
                best_m                  = m;
                r.found                 = 1'b1;
                r.cut_position          = PosWidth'(p);
                r.signal_efficiency     = EffWidth'(se);
                r.background_efficiency = EffWidth'(be);
            end
            sig_head += sig_bins[p];
            bkg_head += bkg_bins[p];
        end
        r.zero_total     = (sig_sum == 0) || (bkg_sum == 0);
        r.store_overflow = dropped;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            loaded             = 0;
            sig_sum            = 0;
            bkg_sum            = 0;
            dropped            = 0;
            target            <= '0;
            match_sel         <= 1'b0;
            o_fail_count      <= 0;
            o_results_checked <= 0;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2:2] == RegTarget[0]) target <= i_pwdata[16:0];
                if (i_paddr[2:2] == RegMatchOn[0]) match_sel <= i_pwdata[0];
            end
            if (i_bin_valid && i_bin_ready) begin
                // Blocking updates here so the search sees the bin just loaded.
                if (loaded < BinDepth) begin
                    sig_bins[loaded] = i_bin_data.signal_count;
                    bkg_bins[loaded] = i_bin_data.background_count;
                    sig_sum          = sig_sum + i_bin_data.signal_count;
                    bkg_sum          = bkg_sum + i_bin_data.background_count;
                    loaded           = loaded + 1;
                end else begin
                    dropped = 1'b1;
                end
                if (i_bin_data.last_bin) begin
                    expected_results.insert(expected_results.size(), search_threshold());
                    loaded  = 0;
                    sig_sum = 0;
                    bkg_sum = 0;
                    dropped = 1'b0;
                end
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: result with no expectation: %p", i_res_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    o_results_checked <= o_results_checked + 1;
                    if (i_res_data.found !== exp_r.found
                        || i_res_data.cut_position !== exp_r.cut_position
                        || i_res_data.signal_efficiency !== exp_r.signal_efficiency
                        || i_res_data.background_efficiency !== exp_r.background_efficiency
                        || i_res_data.zero_total !== exp_r.zero_total
                        || i_res_data.store_overflow !== exp_r.store_overflow) begin
                        if (o_fail_count < 10) begin
                            $display("ERROR: result mismatch");
                            $display("  expected found=%0d pos=%0d seff=%0d beff=%0d zt=%0d ovf=%0d",
                                     exp_r.found, exp_r.cut_position, exp_r.signal_efficiency,
                                     exp_r.background_efficiency, exp_r.zero_total,
                                     exp_r.store_overflow);
                            $display("  actual   found=%0d pos=%0d seff=%0d beff=%0d zt=%0d ovf=%0d",
                                     i_res_data.found, i_res_data.cut_position,
                                     i_res_data.signal_efficiency,
                                     i_res_data.background_efficiency,
                                     i_res_data.zero_total, i_res_data.store_overflow);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/histogram_efficiency_threshold_search_tb.sv -----
module histogram_efficiency_threshold_search_tb;
    import hets_pkg::*;

    localparam int IdleLimit  = 200000;
    localparam int DrainWait  = 100;
    localparam logic [2:0] AddrTarget  = 3'(RegTarget) << 2;
    localparam logic [2:0] AddrMatchOn = 3'(RegMatchOn) << 2;

    typedef enum int {
        FillWide, FillSmall, FillNoSignal, FillNoBackground, FillFull, FillSparse
    } t_fill;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          results_checked;
    int          idle_cycles;
    int          burst_left;
    int          hist_count;
    int          random_bins;
    int          stall_left;
    int          stall_mode_cycles;
    int          stall_mode;

    hets_stream_if #(.T(t_bin))    bin_if ();
    hets_stream_if #(.T(t_result)) res_if ();

    histogram_efficiency_threshold_search dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bin    (bin_if.sink),
        .o_result (res_if.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hets_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_bin_valid       (bin_if.valid),
        .i_bin_ready       (bin_if.ready),
        .i_bin_data        (bin_if.data),
        .i_res_valid       (res_if.valid),
        .i_res_ready       (res_if.ready),
        .i_res_data        (res_if.data),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_pready          (pready),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_results_checked (results_checked)
    );

    always #5 i_clk = ~i_clk;

    // The receiver switches between free flow, scattered stalls and long stalls.
    always @(negedge i_clk) begin
        if (stall_mode_cycles == 0) begin
            stall_mode        <= $urandom_range(0, 2);
            stall_mode_cycles <= $urandom_range(50, 400);
        end else begin
            stall_mode_cycles <= stall_mode_cycles - 1;
        end
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (stall_mode == 1 && $urandom_range(0, 3) == 0) begin
            res_if.ready <= 1'b0;
        end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= $urandom_range(1, 20);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((bin_if.valid && bin_if.ready) || (res_if.valid && res_if.ready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("ERROR: no progress for %0d cycles", IdleLimit);
            $display("** histogram_efficiency_threshold_search: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Settings change only once the block has gone quiet.
    task automatic set_search(input logic [16:0] tgt, input logic mode);
        wait (pending == 0);
        repeat (DrainWait) @(negedge i_clk);
        reg_write(AddrTarget, 32'(tgt));
        reg_write(AddrMatchOn, 32'(mode));
    endtask

    task automatic send_bin(input t_bin b);
        bin_if.valid <= 1'b1;
        bin_if.data  <= b;
        @(posedge i_clk);
        while (!bin_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left = burst_left - 1;
        end else begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 3) != 0) begin
                bin_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
    endtask

    function automatic logic [31:0] pick_count(input t_fill fill, input bit is_signal);
        case (fill)
            FillWide:         return $urandom();
            FillSmall:        return $urandom_range(0, 15);
            FillNoSignal:     return is_signal ? 32'd0 : $urandom_range(0, 1000);
            FillNoBackground: return is_signal ? $urandom_range(0, 1000) : 32'd0;
            FillFull:         return 32'hFFFF_FFFF;
            default:          return ($urandom_range(0, 2) == 0) ? $urandom() : 32'd0;
        endcase
    endfunction

    task automatic send_histogram(input int n_bins, input t_fill fill);
        t_bin b;
        for (int i = 0; i < n_bins; i++) begin
            b.signal_count     = pick_count(fill, 1'b1);
            b.background_count = pick_count(fill, 1'b0);
            b.last_bin         = (i == n_bins - 1);
            send_bin(b);
        end
        bin_if.valid <= 1'b0;
        @(negedge i_clk);
        hist_count++;
    endtask

    function automatic logic [16:0] pick_target();
        case ($urandom_range(0, 5))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return 17'h1FFFF;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        bin_if.valid      = 1'b0;
        bin_if.data       = '0;
        res_if.ready      = 1'b0;
        idle_cycles       = 0;
        burst_left        = 0;
        hist_count        = 0;
        random_bins       = 0;
        stall_left        = 0;
        stall_mode        = 0;
        stall_mode_cycles = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single bin, empty totals, saturated counts, target extremes.
        set_search(17'd32768, 1'b0);
        send_histogram(1, FillFull);
        send_histogram(4, FillSmall);
        send_histogram(3, FillNoBackground);
        send_histogram(3, FillNoSignal);
        set_search(17'd65536, 1'b1);
        send_histogram(4, FillWide);
        send_histogram(2, FillFull);
        set_search(17'h1FFFF, 1'b0);
        send_histogram(3, FillSparse);
        set_search(17'd0, 1'b1);
        send_histogram(2, FillSmall);

        while (random_bins < 820) begin
            int n_bins;
            if (hist_count % 6 == 0)
                set_search(pick_target(), 1'($urandom_range(0, 1)));
            n_bins = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                  : $urandom_range(1, 12);
            send_histogram(n_bins, t_fill'($urandom_range(0, 5)));
            random_bins += n_bins;
        end

        wait (pending == 0);
        repeat (DrainWait) @(negedge i_clk);
        $display("Sent %0d histograms (%0d random bins) with mixed fills and stalls;",
                 hist_count, random_bins);
        $display("checked %0d threshold results across several target settings.",
                 results_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("** histogram_efficiency_threshold_search: PASSED **");
        end else begin
            $display("** histogram_efficiency_threshold_search: FAILED **");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/hets_pkg.sv
hw/rtl/hets_stream_if.sv
hw/rtl/histogram_efficiency_threshold_search.sv
tb/hets_checker.sv
tb/histogram_efficiency_threshold_search_tb.sv
